// ===== design/jerk_limited_velocity_profile_unit_macros.svh =====
// assertion macros for the velocity profile checker
// no dependencies
`ifndef JERK_LIMITED_VELOCITY_PROFILE_UNIT_MACROS_SVH
`define JERK_LIMITED_VELOCITY_PROFILE_UNIT_MACROS_SVH
// implication checked every clock, skipped in reset
`define JLVP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define JLVP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== design/jlvp_pkg.sv =====
// package for the jerk-limited velocity profile unit
// types, constants and sequencer states; no dependencies
package jlvp_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int PERIOD_FRAC     = 24;
    localparam int CFG_WIDTH       = 31;
    localparam int IDX_WIDTH       = 3;
    localparam int WIDE            = 64;

    localparam logic [IDX_WIDTH-1:0] REG_MAX_SPEED = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_MAX_ACCEL = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_MAX_DECEL = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_MAX_JERK  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_PERIOD    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENERGY,
        ST_SQRT,
        ST_TARGET,
        ST_DIV,
        ST_JERK,
        ST_ACCEL,
        ST_INTEG,
        ST_RATE,
        ST_OUT
    } state_t;

    // shared unit request
    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [WIDE-1:0]  num;
        logic [WIDE-1:0]  den;
    } iter_req_t;

    typedef struct packed {
        logic             done;
        logic [WIDE-1:0]  result;
    } iter_rsp_t;
endpackage

// ===== design/jlvp_stream_if.sv =====
// valid/ready stream interface with a payload type parameter
// depends on nothing
interface jlvp_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/jlvp_iter_unit.sv =====
// shared bit-serial unit: 64-bit integer square root and unsigned divide
// depends on jlvp_pkg
module jlvp_iter_unit
    import jlvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  iter_req_t req,
    output iter_rsp_t rsp
);
    logic [WIDE-1:0] rem_reg, rem_next;
    logic [WIDE-1:0] quo_reg, quo_next;
    logic [WIDE-1:0] num_reg, num_next;
    logic [WIDE-1:0] den_reg, den_next;
    logic            div_reg, div_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [WIDE+1:0] trial;
    logic [WIDE+1:0] rsh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        trial     = '0;
        rsh       = '0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            div_next  = req.is_div;
            busy_next = 1'b1;
            cnt_next  = req.is_div ? 7'd64 : 7'd32;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring divide, one quotient bit a cycle
                rsh   = {1'b0, rem_reg, num_reg[WIDE-1]};
                trial = rsh - {2'b00, den_reg};
                num_next = {num_reg[WIDE-2:0], 1'b0};
                if (!trial[WIDE+1])
                begin
                    rem_next = trial[WIDE-1:0];
                    quo_next = {quo_reg[WIDE-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[WIDE-1:0];
                    quo_next = {quo_reg[WIDE-2:0], 1'b0};
                end
            end
            else
            begin
                // digit-by-digit root, two radicand bits a cycle
                rsh   = {rem_reg, num_reg[WIDE-1:WIDE-2]};
                trial = rsh - {quo_reg, 2'b01};
                num_next = {num_reg[WIDE-3:0], 2'b00};
                if (!trial[WIDE+1])
                begin
                    rem_next = trial[WIDE-1:0];
                    quo_next = {quo_reg[WIDE-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh[WIDE-1:0];
                    quo_next = {quo_reg[WIDE-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        den_reg <= den_next;
        div_reg <= div_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;
endmodule

// ===== design/jerk_limited_velocity_profile_unit.sv =====
// jerk-limited velocity profile: one tick per input transfer, rate and
// acceleration kept between ticks. A tick runs on the shared bit-serial unit:
// a 32-step square root then a 64-step divide, plus eight sequencer steps,
// three of them with one multiply each. Ready is low during a tick; the
// result waits in an output register and the next tick may start while it
// is held, but that tick cannot finish until the held result is taken.
// No clearing pass after reset.
// depends on jlvp_pkg, jlvp_stream_if, jlvp_iter_unit
module jerk_limited_velocity_profile_unit
    import jlvp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    jlvp_stream_if.sink            in_ch,
    jlvp_stream_if.source          out_ch
);
    localparam int VW = VALUE_WIDTH;
    localparam logic signed [WIDE-1:0] VMAX_S = (WIDE'(1) <<< (VW - 1)) - WIDE'(1);
    localparam logic [WIDE-1:0] PONE = WIDE'(1) << PERIOD_FRAC;

    logic [CFG_WIDTH-1:0] speed_reg, accel_lim_reg, decel_reg, jerk_reg;
    logic [24:0]          period_reg;

    state_t state_reg, state_next;
    iter_req_t req;
    iter_rsp_t rsp;

    logic signed [VW-1:0]   rate_reg, rate_next, acc_reg, acc_next;
    logic signed [WIDE-1:0] err_reg, err_next;
    logic signed [WIDE-1:0] tgt_reg, tgt_next;
    logic signed [WIDE-1:0] req_reg, req_next;
    logic signed [WIDE-1:0] chg_reg, chg_next;
    logic signed [WIDE-1:0] na_reg, na_next;
    logic signed [WIDE-1:0] nr_reg, nr_next;
    logic                   brk_reg, brk_next;
    logic                   ovalid_reg, ovalid_next;
    logic signed [VW-1:0]   orate_reg, orate_next, oacc_reg, oacc_next;
    logic                   obrk_reg, obrk_next;

    logic [WIDE-1:0] vmax, alim, dlim, jlim, per;
    logic [WIDE-1:0] mag_err, mag_tgt, mag_rate, mag_serr, mag_na, prod;
    logic signed [WIDE-1:0] rate_w, acc_w, serr, lo, hi, tmp;
    logic brk_now;

    jlvp_iter_unit u_iter (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= CFG_WIDTH'(65536);
            accel_lim_reg <= CFG_WIDTH'(65536);
            decel_reg     <= CFG_WIDTH'(65536);
            jerk_reg      <= CFG_WIDTH'(65536);
            period_reg    <= 25'd16777;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_SPEED: speed_reg     <= cfg_data;
                REG_MAX_ACCEL: accel_lim_reg <= cfg_data;
                REG_MAX_DECEL: decel_reg     <= cfg_data;
                REG_MAX_JERK:  jerk_reg      <= cfg_data;
                REG_PERIOD:    period_reg    <= cfg_data[24:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        vmax = (speed_reg == '0) ? WIDE'(1) : WIDE'(speed_reg);
        alim = (accel_lim_reg == '0) ? WIDE'(1) : WIDE'(accel_lim_reg);
        dlim = (decel_reg == '0) ? WIDE'(1) : WIDE'(decel_reg);
        jlim = (jerk_reg == '0) ? WIDE'(1) : WIDE'(jerk_reg);
        per  = (period_reg == '0) ? WIDE'(1) : WIDE'(period_reg);
        if (per > PONE)
            per = PONE;
        rate_w   = WIDE'(rate_reg);
        acc_w    = WIDE'(acc_reg);
        mag_err  = err_reg[WIDE-1] ? WIDE'(0) - err_reg : err_reg;
        mag_tgt  = tgt_reg[WIDE-1] ? WIDE'(0) - tgt_reg : tgt_reg;
        mag_rate = rate_w[WIDE-1] ? WIDE'(0) - rate_w : rate_w;
        serr     = tgt_reg - rate_w;
        mag_serr = serr[WIDE-1] ? WIDE'(0) - serr : serr;
        mag_na   = na_reg[WIDE-1] ? WIDE'(0) - na_reg : na_reg;
        brk_now  = (tgt_reg < 0 && rate_w > 0) || (tgt_reg > 0 && rate_w < 0)
                   || (mag_tgt < mag_rate);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_ch.valid && in_ch.ready) state_next = ST_ENERGY;
            ST_ENERGY: state_next = ST_SQRT;
            ST_SQRT:   if (rsp.done) state_next = ST_TARGET;
            ST_TARGET: state_next = ST_DIV;
            ST_DIV:    if (rsp.done) state_next = ST_JERK;
            ST_JERK:   state_next = ST_ACCEL;
            ST_ACCEL:  state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_RATE;
            ST_RATE:   state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        err_next    = err_reg;
        tgt_next    = tgt_reg;
        req_next    = req_reg;
        chg_next    = chg_reg;
        na_next     = na_reg;
        nr_next     = nr_reg;
        brk_next    = brk_reg;
        rate_next   = rate_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg;
        orate_next  = orate_reg;
        oacc_next   = oacc_reg;
        obrk_next   = obrk_reg;
        req         = '0;
        prod        = '0;
        lo          = '0;
        hi          = '0;
        tmp         = '0;
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid)
                    err_next = WIDE'(in_ch.payload);
            ST_ENERGY:
            begin
                // 2*dec*|err| fits: 31 x 32 bits, then doubled
                req.start  = 1'b1;
                req.is_div = 1'b0;
                req.num    = (dlim * mag_err) << 1;
            end
            ST_SQRT:
                if (rsp.done)
                begin
                    tmp      = (rsp.result > vmax) ? signed'(vmax) : signed'(rsp.result);
                    tgt_next = err_reg[WIDE-1] ? -tmp : tmp;
                end
            ST_TARGET:
            begin
                brk_next   = brk_now;
                req.start  = 1'b1;
                req.is_div = 1'b1;
                req.num    = mag_serr << PERIOD_FRAC;
                req.den    = per;
            end
            ST_DIV:
                if (rsp.done)
                begin
                    tmp = signed'(brk_reg ? dlim : alim);
                    if (rsp.result <= WIDE'(tmp))
                        tmp = signed'(rsp.result);
                    req_next = serr[WIDE-1] ? -tmp : tmp;
                end
            ST_JERK:
            begin
                prod     = (jlim * per) >> PERIOD_FRAC;
                chg_next = signed'(prod);
            end
            ST_ACCEL:
            begin
                lo  = acc_w - chg_reg;
                hi  = acc_w + chg_reg;
                tmp = req_reg;
                if (tmp < lo) tmp = lo;
                if (tmp > hi) tmp = hi;
                if (tmp < -VMAX_S) tmp = -VMAX_S;
                if (tmp > VMAX_S) tmp = VMAX_S;
                na_next = tmp;
            end
            ST_INTEG:
            begin
                prod    = (mag_na * per) >> PERIOD_FRAC;
                tmp     = signed'(prod);
                nr_next = rate_w + (na_reg[WIDE-1] ? -tmp : tmp);
            end
            ST_RATE:
            begin
                tmp = nr_reg;
                if (tmp < -signed'(vmax)) tmp = -signed'(vmax);
                if (tmp > signed'(vmax)) tmp = signed'(vmax);
                if (tmp < -VMAX_S) tmp = -VMAX_S;
                if (tmp > VMAX_S) tmp = VMAX_S;
                nr_next = tmp;
            end
            ST_OUT:
                if (!ovalid_reg || out_ch.ready)
                begin
                    rate_next   = nr_reg[VW-1:0];
                    acc_next    = na_reg[VW-1:0];
                    ovalid_next = 1'b1;
                    orate_next  = nr_reg[VW-1:0];
                    oacc_next   = na_reg[VW-1:0];
                    obrk_next   = brk_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rate_reg   <= '0;
            acc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rate_reg   <= rate_next;
            acc_reg    <= acc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        tgt_reg   <= tgt_next;
        req_reg   <= req_next;
        chg_reg   <= chg_next;
        na_reg    <= na_next;
        nr_reg    <= nr_next;
        brk_reg   <= brk_next;
        orate_reg <= orate_next;
        oacc_reg  <= oacc_next;
        obrk_reg  <= obrk_next;
    end

    assign in_ch.ready             = (state_reg == ST_IDLE);
    assign out_ch.valid            = ovalid_reg;
    assign out_ch.payload.new_rate  = orate_reg;
    assign out_ch.payload.new_accel = oacc_reg;
    assign out_ch.payload.braking   = obrk_reg;
endmodule

// ===== design/jlvp_checker.sv =====
// port-level checker for the velocity profile unit, bound to the top level
// depends on jerk_limited_velocity_profile_unit_macros.svh
`include "jerk_limited_velocity_profile_unit_macros.svh"
module jlvp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // a tick is in progress after a transfer: no second transfer right after one
    `JLVP_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
    // a result never appears the cycle after input is taken
    `JLVP_ASSERT_NEXT(a_no_instant_out, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)
    // held result stays until taken
    `JLVP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind jerk_limited_velocity_profile_unit jlvp_checker u_jlvp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the jerk-limited velocity profile unit
// drives random and directed position errors and checks each tick against a local profile model
// depends on jlvp_pkg, jlvp_stream_if and jerk_limited_velocity_profile_unit
module tb_top;
    import jlvp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0] err_t;
    typedef struct packed {
        logic signed [31:0] new_rate;
        logic signed [31:0] new_accel;
        logic               braking;
    } profile_t;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint unsigned PERIOD_ONE = 64'd16777216;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    jlvp_stream_if #(.payload_t(err_t))     err_ch ();
    jlvp_stream_if #(.payload_t(profile_t)) prof_ch ();

    jerk_limited_velocity_profile_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (err_ch.sink),
        .out_ch    (prof_ch.source)
    );

    // local copy of limits and kept motion state
    longint unsigned lim_speed, lim_accel, lim_decel, lim_jerk, tick_period;
    longint          kept_rate, kept_accel;

    err_t     pending_errs[$];
    profile_t expected_profiles[$];
    int       mismatch_count;
    int       send_gap, recv_stall;
    bit       send_bursty, recv_bursty;
    bit       err_taken, prof_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned at_least_one(input longint unsigned v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    // one control tick of the profile; updates kept rate and acceleration
    function automatic profile_t profile_tick(input err_t err);
        longint          e, vmax, tgt, lim, serr, req, change, na, nr, step;
        longint unsigned dec, p, q, tmag;
        bit              brk;
        profile_t        res;
        e    = err;
        vmax = at_least_one(lim_speed);
        dec  = at_least_one(lim_decel);
        p    = at_least_one(tick_period);
        if (p > PERIOD_ONE)
            p = PERIOD_ONE;
        tmag = floor_sqrt(2 * dec * magnitude(e));
        if (tmag > vmax)
            tmag = vmax;
        tgt = (e < 0) ? -longint'(tmag) : longint'(tmag);
        brk = (tgt < 0 && kept_rate > 0) || (tgt > 0 && kept_rate < 0)
              || magnitude(tgt) < magnitude(kept_rate);
        lim = brk ? dec : at_least_one(lim_accel);
        serr = tgt - kept_rate;
        q = (magnitude(serr) << PERIOD_FRAC) / p;
        req = (q > lim) ? lim : longint'(q);
        if (serr < 0)
            req = -req;
        change = (at_least_one(lim_jerk) * p) >> PERIOD_FRAC;
        na = clamp(req, kept_accel - change, kept_accel + change);
        na = clamp(na, -VAL_MAX, VAL_MAX);
        step = (magnitude(na) * p) >> PERIOD_FRAC;
        nr = kept_rate + ((na < 0) ? -step : step);
        nr = clamp(nr, -vmax, vmax);
        nr = clamp(nr, -VAL_MAX, VAL_MAX);
        kept_rate  = nr;
        kept_accel = na;
        res.new_rate  = nr[31:0];
        res.new_accel = na[31:0];
        res.braking   = brk;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // input side: transfer detection and prediction
    always @(posedge clk)
    begin
        err_taken = 1'b0;
        if (rst_n && err_ch.valid && err_ch.ready)
        begin
            expected_profiles.push_back(profile_tick(err_ch.payload));
            err_taken = 1'b1;
        end
    end

    // driver: presents the next queued error after a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            err_ch.valid   <= 1'b0;
            err_ch.payload <= '0;
        end
        else if (!err_ch.valid || err_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                err_ch.valid <= 1'b0;
            end
            else if (pending_errs.size() > 0)
            begin
                err_ch.payload <= pending_errs.pop_front();
                err_ch.valid   <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    send_bursty = ~send_bursty;
                send_gap = send_bursty ? $urandom_range(0, 17) : 0;
            end
            else
                err_ch.valid <= 1'b0;
        end
    end

    // monitor: compares each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        profile_t want;
        prof_taken = 1'b0;
        if (rst_n && prof_ch.valid && prof_ch.ready)
        begin
            prof_taken = 1'b1;
            if (expected_profiles.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_profiles.pop_front();
                if (prof_ch.payload.new_rate !== want.new_rate)
                    report("new_rate", prof_ch.payload.new_rate, want.new_rate);
                if (prof_ch.payload.new_accel !== want.new_accel)
                    report("new_accel", prof_ch.payload.new_accel, want.new_accel);
                if (prof_ch.payload.braking !== want.braking)
                    report("braking", prof_ch.payload.braking, want.braking);
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            prof_ch.ready <= 1'b0;
        else
        begin
            if (prof_taken)
            begin
                if ($urandom_range(0, 63) == 0)
                    recv_bursty = ~recv_bursty;
                recv_stall = recv_bursty ? $urandom_range(0, 17) : 0;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                prof_ch.ready <= 1'b0;
            end
            else
                prof_ch.ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_errs.size() != 0 || err_ch.valid || expected_profiles.size() != 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input longint unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_WIDTH-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_limits(input longint unsigned spd, input longint unsigned acc,
                              input longint unsigned dec, input longint unsigned jrk,
                              input longint unsigned per);
        wait_idle();
        write_reg(REG_MAX_SPEED, spd);
        write_reg(REG_MAX_ACCEL, acc);
        write_reg(REG_MAX_DECEL, dec);
        write_reg(REG_MAX_JERK, jrk);
        write_reg(REG_PERIOD, per);
        lim_speed   = spd & 64'h7FFFFFFF;
        lim_accel   = acc & 64'h7FFFFFFF;
        lim_decel   = dec & 64'h7FFFFFFF;
        lim_jerk    = jrk & 64'h7FFFFFFF;
        tick_period = per & 64'h1FFFFFF;
    endtask

    function automatic longint unsigned rand_limit();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 65536);
            1:       return $urandom_range(65536, 65536 * 256);
            2:       return {$urandom} & 32'h7FFFFFFF;
            default: return $urandom_range(65536 * 256, 32'h7FFFFFFF);
        endcase
    endfunction

    // mostly approach runs toward a target, plus noise and reversals
    task automatic queue_random_errs(input int count);
        int   n, k, len;
        err_t pos, stepsz;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    pending_errs.push_back($urandom);
                    n++;
                end
                2:
                begin
                    pending_errs.push_back($urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000);
                    n++;
                end
                default:
                begin
                    len    = $urandom_range(4, 30);
                    pos    = $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFFFFFF)
                                                  : $urandom_range(0, 65536 * 64);
                    stepsz = pos / len + 1;
                    if ($urandom_range(0, 1))
                        pos = -pos;
                    for (k = 0; k < len; k++)
                    begin
                        pending_errs.push_back(pos);
                        pos = (pos > 0) ? pos - stepsz : pos + stepsz;
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_MAX_SPEED;
        cfg_data       = '0;
        err_ch.valid   = 1'b0;
        err_ch.payload = '0;
        prof_ch.ready  = 1'b0;
        mismatch_count = 0;
        send_gap       = 0;
        recv_stall     = 0;
        send_bursty    = 1'b0;
        recv_bursty    = 1'b1;
        lim_speed      = 65536;
        lim_accel      = 65536;
        lim_decel      = 65536;
        lim_jerk       = 65536;
        tick_period    = 16777;
        kept_rate      = 0;
        kept_accel     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at reset limits
        pending_errs = '{0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000, 65536, -65536, 0};
        // build up speed then reverse so braking and opposing targets show up
        set_limits(65536 * 4, 65536 * 64, 65536 * 64, 32'h7FFFFFFF, 16777 * 100);
        repeat (6) pending_errs.push_back(32'sh7FFFFFFF);
        repeat (3) pending_errs.push_back(32'sh80000000);
        pending_errs.push_back(0);
        pending_errs.push_back(5);
        // full-scale limits and a one second tick
        set_limits(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, PERIOD_ONE);
        repeat (3) pending_errs.push_back(32'sh7FFFFFFF);
        queue_random_errs(60);
        // speed limit lowered under the kept rate
        wait_idle();
        pending_errs.push_back(32'sh7FFFFFFF);
        set_limits(1000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, PERIOD_ONE);
        pending_errs.push_back(32'sh7FFFFFFF);
        queue_random_errs(40);
        // smallest limits, then limits written as zero
        set_limits(1, 1, 1, 1, 1);
        queue_random_errs(60);
        set_limits(0, 0, 0, 0, 0);
        queue_random_errs(60);
        // period beyond one second
        set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit(), 25'h1FFFFFF);
        queue_random_errs(80);
        set_limits(65536 * 100, 65536 * 1000, 65536 * 2000, 65536 * 50000, 16777);
        queue_random_errs(150);
        repeat (6)
        begin
            set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit(),
                       $urandom_range(1, 32'h1FFFFFF));
            queue_random_errs(110);
        end

        do
            @(posedge clk);
        while (pending_errs.size() != 0 || err_ch.valid || expected_profiles.size() != 0);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
